[design/lz_pkg.sv]
// Shared constants and types of the LZ77 token compressor.
`default_nettype none
package lz_pkg;

  localparam int WINDOW_DEF    = 1024;
  localparam int MAX_MATCH_DEF = 16;
  localparam int MIN_MATCH     = 3;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_STREAM = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_RESULT = 7'b0100000,
    ST_ENDM   = 7'b1000000
  } lz_state_e;

endpackage
`default_nettype wire

[design/lz_cell.sv]
// One cell of the match row: a lookahead byte, a window byte and their compare.
`default_nettype none
module lz_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_lk_i,
  input  wire logic       shift_win_i,
  input  wire logic [7:0] lk_i,
  input  wire logic [7:0] win_i,
  output logic      [7:0] lk_o,
  output logic      [7:0] win_o,
  output logic            eq_o
);

  logic [7:0] lk_q;
  logic [7:0] win_q;

  always_ff @(posedge clk_i) begin
    if (shift_lk_i) begin
      lk_q <= lk_i;
    end
    if (shift_win_i) begin
      win_q <= win_i;
    end
  end

  assign lk_o  = lk_q;
  assign win_o = win_q;
  assign eq_o  = (lk_q == win_q);

endmodule
`default_nettype wire

[design/lz77_token_compressor_core.sv]
// Top level of the LZ77 token compressor: history ring, match cell row and control.
`default_nettype none
// A data byte is taken while the core is idle. Once MAX_MATCH bytes are
// pending, or while an end transaction flushes, tokens are formed one at a
// time, and each token may also wait on the receiver at the output register.
// The pace of each token is set by the single read port of the history ring,
// which
// streams the pending bytes into the lookahead registers of the cell row and
// then the history bytes, one per cycle, through the window registers of the
// row. Each cycle the row compares a whole candidate window against the
// lookahead and the farthest longest match is kept. An end transaction yields
// its tokens (last low) and then an end marker with last high. The ring needs
// no clearing after reset: only written entries ever decide a token.
module lz77_token_compressor_core
  import lz_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_MATCH = MAX_MATCH_DEF,
  localparam int DW = $clog2(WINDOW + 1),
  localparam int LW = $clog2(MAX_MATCH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          kind_i,
  input  wire logic [7:0]    data_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               is_match_o,
  output logic [7:0]         literal_o,
  output logic [LW-1:0]      match_length_o,
  output logic [DW-1:0]      match_distance_o,
  output logic               last_o
);

  localparam int RING = WINDOW + MAX_MATCH;
  localparam int AW   = $clog2(RING);
  localparam logic [AW:0]   RING_W = (AW + 1)'(RING);
  localparam logic [AW-1:0] RING_LAST = AW'(RING - 1);
  localparam logic [LW-1:0] MM_L = LW'(MAX_MATCH);
  localparam logic [LW-1:0] MIN_L = LW'(MIN_MATCH);
  localparam logic [DW-1:0] WIN_D = DW'(WINDOW);

  lz_state_e state_q, state_d;

  logic [AW-1:0] wp_q, wp_d;
  logic [LW-1:0] pend_q, pend_d;
  logic [DW-1:0] cons_q, cons_d;
  logic          flush_q, flush_d;
  logic          last_q, last_d;

  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] rd_cnt_q, rd_cnt_d;
  logic          rd_en;
  logic          rd_tgt;
  logic          rd_vld_q, rd_tgt_q;
  logic [7:0]    rd_data_q;

  logic [AW-1:0] win_n_q;
  logic          new_win_q;
  logic [DW-1:0] eval_q;
  logic [LW-1:0] best_len_q;
  logic [DW-1:0] best_dist_q;

  logic          out_valid_q;
  logic          out_load;
  logic          out_free;
  logic          is_match_d, is_match_q;
  logic [7:0]    literal_d, literal_q;
  logic [LW-1:0] len_d, len_q;
  logic [DW-1:0] dist_d, dist_q;
  logic          olast_d, olast_q;

  logic [7:0] mem_q [RING];

  logic [7:0] lk_w  [MAX_MATCH];
  logic [7:0] win_w [MAX_MATCH];
  logic       eq_w  [MAX_MATCH];

  logic          in_acc;
  logic [AW:0]   start_sum;
  logic [AW:0]   base_sum;
  logic [AW-1:0] base_addr;
  logic [AW:0]   stream_len;
  logic          eval;
  logic [LW-1:0] run_len;
  logic [LW-1:0] adv;
  logic [DW:0]   cons_sum;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == RING_LAST) ? '0 : a + 1'b1;
  endfunction

  // The row: cell MAX_MATCH-1 takes bytes from the ring, the others from the
  // neighbor above, so after a fill cell j holds the j-th byte of the run.
  for (genvar j = 0; j < MAX_MATCH; j++) begin : g_cell
    logic [7:0] lk_in, win_in;
    if (j == MAX_MATCH - 1) begin : g_top
      assign lk_in  = rd_data_q;
      assign win_in = rd_data_q;
    end else begin : g_mid
      assign lk_in  = lk_w[j+1];
      assign win_in = win_w[j+1];
    end
    lz_cell u_cell (
      .clk_i       (clk_i),
      .shift_lk_i  (rd_vld_q && !rd_tgt_q),
      .shift_win_i (rd_vld_q && rd_tgt_q),
      .lk_i        (lk_in),
      .win_i       (win_in),
      .lk_o        (lk_w[j]),
      .win_o       (win_w[j]),
      .eq_o        (eq_w[j])
    );
  end

  // Length of the match of the window now in the row: leading equal cells,
  // counted only over pending bytes.
  always_comb begin
    logic run;
    run     = 1'b1;
    run_len = '0;
    for (int j = 0; j < MAX_MATCH; j++) begin
      run = run && eq_w[j] && (LW'(j) < pend_q);
      if (run) begin
        run_len = LW'(j + 1);
      end
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign start_sum  = {1'b0, wp_q} + RING_W - (AW + 1)'(pend_q);
  assign base_sum   = {1'b0, start_q} + RING_W - (AW + 1)'(cons_q);
  assign base_addr  = (base_sum >= RING_W) ? AW'(base_sum - RING_W) : AW'(base_sum);
  assign stream_len = (AW + 1)'(cons_q) + (AW + 1)'(MAX_MATCH - 1);

  assign eval   = new_win_q && (win_n_q >= AW'(MAX_MATCH));
  assign rd_tgt = (state_q == ST_STREAM);
  assign rd_en  = (state_q == ST_LOAD) || (state_q == ST_STREAM);

  assign adv      = (best_len_q < MIN_L) ? LW'(1) : best_len_q;
  assign cons_sum = {1'b0, cons_q} + (DW + 1)'(adv);

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    pend_d     = pend_q;
    cons_d     = cons_q;
    flush_d    = flush_q;
    last_d     = last_q;
    start_d    = start_q;
    rd_addr_d  = rd_addr_q;
    rd_cnt_d   = rd_cnt_q;
    out_load   = 1'b0;
    is_match_d = 1'b0;
    literal_d  = '0;
    len_d      = '0;
    dist_d     = '0;
    olast_d    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!kind_i) begin
            wp_d   = addr_inc(wp_q);
            pend_d = pend_q + 1'b1;
            if (pend_q + 1'b1 == MM_L) begin
              flush_d = 1'b0;
              last_d  = 1'b1;
              state_d = ST_PREP;
            end
          end else begin
            flush_d = 1'b1;
            last_d  = 1'b0;
            state_d = (pend_q != '0) ? ST_PREP : ST_ENDM;
          end
        end
      end
      ST_PREP: begin
        start_d   = (start_sum >= RING_W) ? AW'(start_sum - RING_W) : AW'(start_sum);
        rd_addr_d = start_d;
        rd_cnt_d  = '0;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        rd_addr_d = addr_inc(rd_addr_q);
        rd_cnt_d  = rd_cnt_q + 1'b1;
        if (rd_cnt_q == AW'(MAX_MATCH - 1)) begin
          rd_cnt_d  = '0;
          rd_addr_d = base_addr;
          state_d   = (cons_q == '0) ? ST_DRAIN : ST_STREAM;
        end
      end
      ST_STREAM: begin
        rd_addr_d = addr_inc(rd_addr_q);
        rd_cnt_d  = rd_cnt_q + 1'b1;
        if ((AW + 1)'(rd_cnt_q) == stream_len - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (eval_q == cons_q && !new_win_q && !rd_vld_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          olast_d  = last_q;
          if (best_len_q < MIN_L) begin
            literal_d = lk_w[0];
          end else begin
            is_match_d = 1'b1;
            len_d      = best_len_q;
            dist_d     = best_dist_q;
          end
          pend_d = pend_q - adv;
          cons_d = (cons_sum > (DW + 1)'(WIN_D)) ? WIN_D : DW'(cons_sum);
          if (flush_q) begin
            state_d = (pend_d != '0) ? ST_PREP : ST_ENDM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ENDM: begin
        if (out_free) begin
          out_load   = 1'b1;
          is_match_d = 1'b1;
          olast_d    = 1'b1;
          wp_d       = '0;
          pend_d     = '0;
          cons_d     = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      pend_q      <= '0;
      cons_q      <= '0;
      flush_q     <= 1'b0;
      last_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_tgt_q    <= 1'b0;
      new_win_q   <= 1'b0;
      win_n_q     <= '0;
      eval_q      <= '0;
      out_valid_q <= 1'b0;
      rd_cnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      pend_q    <= pend_d;
      cons_q    <= cons_d;
      flush_q   <= flush_d;
      last_q    <= last_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_vld_q  <= rd_en;
      rd_tgt_q  <= rd_tgt;
      new_win_q <= rd_vld_q && rd_tgt_q;
      if (state_q == ST_PREP) begin
        win_n_q <= '0;
        eval_q  <= '0;
      end else begin
        if (rd_vld_q && rd_tgt_q) begin
          win_n_q <= win_n_q + 1'b1;
        end
        if (eval) begin
          eval_q <= eval_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Candidates come from the farthest distance down, so only a strictly
  // longer match replaces the best one.
  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    rd_addr_q <= rd_addr_d;
    if (state_q == ST_PREP) begin
      best_len_q  <= '0;
      best_dist_q <= '0;
    end else if (eval && run_len > best_len_q) begin
      best_len_q  <= run_len;
      best_dist_q <= cons_q - eval_q;
    end
    if (out_load) begin
      is_match_q <= is_match_d;
      literal_q  <= literal_d;
      len_q      <= len_d;
      dist_q     <= dist_d;
      olast_q    <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !kind_i) begin
      mem_q[wp_q] <= data_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_match_o       = is_match_q;
  assign literal_o        = literal_q;
  assign match_length_o   = len_q;
  assign match_distance_o = dist_q;
  assign last_o           = olast_q;

`ifndef SYNTHESIS
  a_pend_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MM_L) else $error("pending count above MAX_MATCH");
  a_cons_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cons_q <= WIN_D) else $error("consumed count above WINDOW");
  a_best_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> (best_len_q <= pend_q))
    else $error("match longer than pending bytes");
  a_end_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENDM && out_free) |=> (pend_q == '0 && cons_q == '0 && out_valid_q))
    else $error("end marker did not empty the block");
`endif

endmodule
`default_nettype wire

[tb/sv/lz77_token_compressor_core_tb.sv]
// Self-checking testbench of the LZ77 token compressor core.
`timescale 1ns / 100ps
module lz77_token_compressor_core_tb;
  import lz_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int MAXM = MAX_MATCH_DEF;
  localparam int RING = WIN + MAXM;
  localparam int DW = $clog2(WIN + 1);
  localparam int LW = $clog2(MAXM + 1);
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END = 1'b1;
  localparam int NUM_ITEMS = 420;
  localparam longint CYCLE_LIMIT = 64'd12000000;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic          is_match;
    logic [7:0]    literal;
    logic [LW-1:0] length;
    logic [DW-1:0] distance;
    logic          last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [7:0] in_data = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_match, last;
  logic [7:0] literal;
  logic [LW-1:0] match_length;
  logic [DW-1:0] match_distance;

  lz77_token_compressor_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(in_kind), .data_byte_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .is_match_o(is_match), .literal_o(literal),
    .match_length_o(match_length), .match_distance_o(match_distance),
    .last_o(last)
  );

  byte_item_t pending_items[$];
  token_t expected_tokens[$];
  int error_count = 0;
  bit stimulus_done = 1'b0;
  bit calm_phase = 1'b0;
  bit hold_request = 1'b0;
  longint cycle_count = 0;

  // Predictor state: a mirror of the ring and its counters.
  logic [7:0] ring_mem[RING];
  int wr_pos = 0;
  int n_pending = 0;
  int n_consumed = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Encodes one token from the front of the pending bytes and queues it.
  task automatic encode_token(input logic is_last);
    int start, lim, best_len, best_dist, len, adv;
    token_t tok;
    start = (wr_pos + RING - n_pending) % RING;
    lim = (n_consumed < WIN) ? n_consumed : WIN;
    best_len = 0;
    best_dist = 0;
    for (int d = lim; d >= 1; d--) begin
      len = 0;
      while (len < MAXM && len < n_pending &&
             ring_mem[(start + len) % RING] == ring_mem[(start + RING - d + len) % RING])
        len++;
      if (len > best_len) begin
        best_len = len;
        best_dist = d;
      end
    end
    tok = '0;
    tok.last = is_last;
    if (best_len < MIN_MATCH) begin
      tok.literal = ring_mem[start];
      adv = 1;
    end else begin
      tok.is_match = 1'b1;
      tok.length = LW'(best_len);
      tok.distance = DW'(best_dist);
      adv = best_len;
    end
    expected_tokens.push_back(tok);
    if (adv > n_pending) adv = n_pending;
    n_pending -= adv;
    n_consumed += adv;
    if (n_consumed > WIN) n_consumed = WIN;
  endtask

  task automatic predict_tokens(input byte_item_t item);
    token_t tok;
    int n;
    if (item.kind == KIND_DATA) begin
      ring_mem[wr_pos] = item.data;
      wr_pos = (wr_pos + 1) % RING;
      n_pending++;
      if (n_pending >= MAXM) encode_token(1'b1);
    end else begin
      n = 0;
      while (n_pending > 0 && n < MAXM) begin
        encode_token(1'b0);
        n++;
      end
      tok = '0;
      tok.is_match = 1'b1;
      tok.last = 1'b1;
      expected_tokens.push_back(tok);
      wr_pos = 0;
      n_pending = 0;
      n_consumed = 0;
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    pending_items.push_back('{kind: KIND_DATA, data: b});
  endtask

  task automatic add_end(input logic [7:0] junk);
    pending_items.push_back('{kind: KIND_END, data: junk});
  endtask

  // Stimulus: directed cases, then streams with random repetition structure.
  initial begin
    int len, mode, alpha, copy_dist;
    byte_item_t tmp[$];
    add_end(8'hFF);                       // end with nothing pending
    add_byte(8'h00); add_byte(8'hFF); add_end(8'h5A);   // short flush of literals
    for (int i = 0; i < 18; i++) add_byte(8'hAA);        // overlapping run
    add_end(8'h00);
    for (int i = 0; i < 20; i++) add_byte(8'((i % 5) * 51)); // periodic pattern
    add_end(8'h00);
    while (pending_items.size() < NUM_ITEMS - 1) begin
      mode = $urandom_range(0, 9);
      len = (mode == 0) ? $urandom_range(150, 300) : $urandom_range(0, 60);
      if (len > NUM_ITEMS - 1 - pending_items.size())
        len = NUM_ITEMS - 1 - pending_items.size();
      alpha = $urandom_range(1, 3) == 1 ? 256 : $urandom_range(2, 6);
      tmp.delete();
      for (int i = 0; i < len; i++) begin
        if (i > 4 && $urandom_range(0, 2) == 0) begin
          copy_dist = $urandom_range(1, (i < 40) ? i : 40);
          tmp.push_back(tmp[i - copy_dist]);
        end else
          tmp.push_back('{kind: KIND_DATA, data: 8'($urandom_range(0, alpha - 1)) ^
                          ((alpha == 256) ? 8'h00 : 8'($urandom_range(0, 1) * 8'h80))});
      end
      foreach (tmp[i]) pending_items.push_back(tmp[i]);
      add_end(8'($urandom));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: offers queued items with random idle bursts.
  int drv_idle = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_tokens('{kind: in_kind, data: in_data});
      if (!in_valid || in_ready) begin
        if (drv_idle > 0) begin
          drv_idle <= drv_idle - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_kind <= pending_items[0].kind;
          in_data <= pending_items[0].data;
          void'(pending_items.pop_front());
          if (!calm_phase && $urandom_range(0, 5) == 0) drv_idle <= $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: compares every accepted token with the oldest expectation.
  int mon_idle = 0;
  int hold_left = 0;
  always @(posedge clk or negedge rst_n) begin
    token_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("Unexpected token at cycle %0d", cycle_count);
          error_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (is_match !== want.is_match) report_mismatch("is_match", is_match, want.is_match);
          if (literal !== want.literal) report_mismatch("literal", literal, want.literal);
          if (match_length !== want.length)
            report_mismatch("match_length", match_length, want.length);
          if (match_distance !== want.distance)
            report_mismatch("match_distance", match_distance, want.distance);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
      if (hold_request) begin
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (mon_idle > 0) begin
        mon_idle <= mon_idle - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 4) == 0) mon_idle <= $urandom_range(1, 5);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Long receiver hold-off early on so the block backs up its input.
    repeat (300) @(posedge clk);
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    wait (pending_items.size() < 80);
    calm_phase <= 1'b1;
    wait (stimulus_done && expected_tokens.size() == 0);
    repeat (2 * WIN + 200) @(posedge clk);
    if (error_count == 0 && expected_tokens.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
design/lz_pkg.sv
design/lz_cell.sv
design/lz77_token_compressor_core.sv
tb/sv/lz77_token_compressor_core_tb.sv
